>>> hw/rtl/wmh_pkg.sv
// ----------------------------------------------------------------------------
// wmh_pkg
// Shared types, command codes and constants of the word mix hash core.
// ----------------------------------------------------------------------------
package wmh_pkg;

   localparam logic [63:0] GOLD_K    = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] GOLD_K2   = 64'h3c6ef372fe94f82a;
   localparam logic [63:0] GOLD_K3   = 64'hdaa66d2c7ddf743f;
   localparam logic [63:0] FULL_MUL  = 64'h3c79ac492ba7b653;
   localparam logic [63:0] PART_MUL  = 64'h1c69b3f74ac4ae35;
   localparam logic [63:0] FMIX_MUL1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_MUL2 = 64'hc4ceb9fe1a85ec53;

   // Datapath operations.
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_CAPTURE = 4'd1;
   localparam logic [3:0] OP_MUL0    = 4'd2;
   localparam logic [3:0] OP_MUL1    = 4'd3;
   localparam logic [3:0] OP_MUL2    = 4'd4;
   localparam logic [3:0] OP_SEED    = 4'd5;
   localparam logic [3:0] OP_MIX     = 4'd6;
   localparam logic [3:0] OP_TAKE    = 4'd7;
   localparam logic [3:0] OP_FMIX_A  = 4'd8;
   localparam logic [3:0] OP_FMIX_P  = 4'd9;
   localparam logic [3:0] OP_FINAL   = 4'd10;
   localparam logic [3:0] OP_OUT     = 4'd11;

   // Multiplier constant selects.
   localparam logic [2:0] K_GOLD = 3'd0;
   localparam logic [2:0] K_FULL = 3'd1;
   localparam logic [2:0] K_PART = 3'd2;
   localparam logic [2:0] K_FM1  = 3'd3;
   localparam logic [2:0] K_FM2  = 3'd4;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  valid_bytes;
      logic        last_word;
      logic [30:0] message_length;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word0;
      logic [63:0] digest_word1;
      logic [63:0] digest_word2;
      logic [63:0] digest_word3;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] ksel;
   } cmd_type;

   typedef struct packed {
      logic kind_full;
      logic kind_none;
      logic last;
   } stat_type;

endpackage

>>> hw/rtl/wmh_datapath.sv
// ----------------------------------------------------------------------------
// wmh_datapath
// Accumulator, operand and product registers around one shared 32x32
// multiplier, plus the seed register and the digest output register.
// ----------------------------------------------------------------------------
module wmh_datapath (
   input  logic              clock,
   input  logic              reset,
   input  wmh_pkg::cmd_type  cmd,
   input  wmh_pkg::req_type  req_data,
   input  logic              csr_wr_en,
   input  logic [63:0]       csr_wr_data,
   output wmh_pkg::stat_type stat,
   output wmh_pkg::rsp_type  rsp_data
);

   logic [63:0]      seed_ff;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      op_ff, op_in;
   logic [63:0]      prod_ff, prod_in;
   logic [63:0]      word_ff, word_in;
   logic             full_ff, full_in;
   logic             none_ff, none_in;
   logic             last_ff, last_in;
   wmh_pkg::rsp_type out_ff, out_in;

   logic [63:0] kval;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] mixv;
   logic [63:0] masked;

   always_comb begin
      case (cmd.ksel)
         wmh_pkg::K_GOLD: kval = wmh_pkg::GOLD_K;
         wmh_pkg::K_FULL: kval = wmh_pkg::FULL_MUL;
         wmh_pkg::K_PART: kval = wmh_pkg::PART_MUL;
         wmh_pkg::K_FM1:  kval = wmh_pkg::FMIX_MUL1;
         wmh_pkg::K_FM2:  kval = wmh_pkg::FMIX_MUL2;
         default:         kval = wmh_pkg::GOLD_K;
      endcase
   end

   // The low 64 bits of a 64x64 product take three 32x32 partial products.
   assign mul_a = (cmd.op == wmh_pkg::OP_MUL1) ? op_ff[63:32] : op_ff[31:0];
   assign mul_b = (cmd.op == wmh_pkg::OP_MUL2) ? kval[63:32] : kval[31:0];
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked[8*i +: 8] = (4'(i) < req_data.valid_bytes) ? req_data.data_word[8*i +: 8]
                                                          : 8'h00;
      end
   end

   assign mixv = acc_ff ^ word_ff;

   always_comb begin
      acc_in  = acc_ff;
      op_in   = op_ff;
      prod_in = prod_ff;
      word_in = word_ff;
      full_in = full_ff;
      none_in = none_ff;
      last_in = last_ff;
      out_in  = out_ff;
      unique case (cmd.op)
         wmh_pkg::OP_NONE: begin
         end
         wmh_pkg::OP_CAPTURE: begin
            op_in   = {33'd0, req_data.message_length};
            word_in = masked;
            full_in = req_data.valid_bytes >= 4'd8;
            none_in = req_data.valid_bytes == 4'd0;
            last_in = req_data.last_word;
         end
         wmh_pkg::OP_MUL0: prod_in = mul_p;
         wmh_pkg::OP_MUL1,
         wmh_pkg::OP_MUL2: prod_in = prod_ff + {mul_p[31:0], 32'd0};
         wmh_pkg::OP_SEED: acc_in = seed_ff ^ prod_ff;
         wmh_pkg::OP_MIX: begin
            op_in = full_ff ? {mixv[36:0], mixv[63:37]} : {mixv[32:0], mixv[63:33]};
         end
         wmh_pkg::OP_TAKE:    acc_in = prod_ff;
         wmh_pkg::OP_FMIX_A:  op_in  = acc_ff ^ {33'd0, acc_ff[63:33]};
         wmh_pkg::OP_FMIX_P:  op_in  = prod_ff ^ {33'd0, prod_ff[63:33]};
         wmh_pkg::OP_FINAL:   acc_in = prod_ff ^ {33'd0, prod_ff[63:33]};
         wmh_pkg::OP_OUT: begin
            out_in.digest_word0 = acc_ff;
            out_in.digest_word1 = acc_ff + wmh_pkg::GOLD_K;
            out_in.digest_word2 = acc_ff + wmh_pkg::GOLD_K2;
            out_in.digest_word3 = acc_ff + wmh_pkg::GOLD_K3;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 64'd0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      op_ff   <= op_in;
      prod_ff <= prod_in;
      word_ff <= word_in;
      full_ff <= full_in;
      none_ff <= none_in;
      last_ff <= last_in;
      out_ff  <= out_in;
   end

   assign stat.kind_full = full_ff;
   assign stat.kind_none = none_ff;
   assign stat.last      = last_ff;
   assign rsp_data       = out_ff;

endmodule

>>> hw/rtl/wmh_control.sv
// ----------------------------------------------------------------------------
// wmh_control
// Sequencer that steps the datapath through seeding, mixing and finalizing
// of each word, and owns the handshake and message state.
// ----------------------------------------------------------------------------
module wmh_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  wmh_pkg::stat_type stat,
   output wmh_pkg::cmd_type  cmd
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_INIT_M0 = 5'd1;
   localparam logic [4:0] S_INIT_M1 = 5'd2;
   localparam logic [4:0] S_INIT_M2 = 5'd3;
   localparam logic [4:0] S_SEED    = 5'd4;
   localparam logic [4:0] S_MIX     = 5'd5;
   localparam logic [4:0] S_MIX_M0  = 5'd6;
   localparam logic [4:0] S_MIX_M1  = 5'd7;
   localparam logic [4:0] S_MIX_M2  = 5'd8;
   localparam logic [4:0] S_TAKE    = 5'd9;
   localparam logic [4:0] S_F1      = 5'd10;
   localparam logic [4:0] S_F1_M0   = 5'd11;
   localparam logic [4:0] S_F1_M1   = 5'd12;
   localparam logic [4:0] S_F1_M2   = 5'd13;
   localparam logic [4:0] S_F2      = 5'd14;
   localparam logic [4:0] S_F2_M0   = 5'd15;
   localparam logic [4:0] S_F2_M1   = 5'd16;
   localparam logic [4:0] S_F2_M2   = 5'd17;
   localparam logic [4:0] S_FIN     = 5'd18;
   localparam logic [4:0] S_OUT     = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       mid_ff, mid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] mix_k;
   logic [4:0] after_data;

   assign mix_k = stat.kind_full ? wmh_pkg::K_FULL : wmh_pkg::K_PART;
   assign after_data = stat.last ? S_F1 : S_IDLE;

   always_comb begin
      state_in     = state_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = wmh_pkg::OP_NONE;
      cmd.ksel     = wmh_pkg::K_GOLD;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = wmh_pkg::OP_CAPTURE;
               state_in = mid_ff ? S_MIX : S_INIT_M0;
            end
         end
         S_INIT_M0: begin
            cmd.op   = wmh_pkg::OP_MUL0;
            state_in = S_INIT_M1;
         end
         S_INIT_M1: begin
            cmd.op   = wmh_pkg::OP_MUL1;
            state_in = S_INIT_M2;
         end
         S_INIT_M2: begin
            cmd.op   = wmh_pkg::OP_MUL2;
            state_in = S_SEED;
         end
         S_SEED: begin
            cmd.op   = wmh_pkg::OP_SEED;
            state_in = S_MIX;
         end
         S_MIX: begin
            // A word with no valid bytes is not mixed in.
            if (stat.kind_none) begin
               state_in = after_data;
               mid_in   = !stat.last;
            end else begin
               cmd.op   = wmh_pkg::OP_MIX;
               state_in = S_MIX_M0;
            end
         end
         S_MIX_M0: begin
            cmd.op   = wmh_pkg::OP_MUL0;
            cmd.ksel = mix_k;
            state_in = S_MIX_M1;
         end
         S_MIX_M1: begin
            cmd.op   = wmh_pkg::OP_MUL1;
            cmd.ksel = mix_k;
            state_in = S_MIX_M2;
         end
         S_MIX_M2: begin
            cmd.op   = wmh_pkg::OP_MUL2;
            cmd.ksel = mix_k;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            cmd.op   = wmh_pkg::OP_TAKE;
            state_in = after_data;
            mid_in   = !stat.last;
         end
         S_F1: begin
            cmd.op   = wmh_pkg::OP_FMIX_A;
            state_in = S_F1_M0;
         end
         S_F1_M0: begin
            cmd.op   = wmh_pkg::OP_MUL0;
            cmd.ksel = wmh_pkg::K_FM1;
            state_in = S_F1_M1;
         end
         S_F1_M1: begin
            cmd.op   = wmh_pkg::OP_MUL1;
            cmd.ksel = wmh_pkg::K_FM1;
            state_in = S_F1_M2;
         end
         S_F1_M2: begin
            cmd.op   = wmh_pkg::OP_MUL2;
            cmd.ksel = wmh_pkg::K_FM1;
            state_in = S_F2;
         end
         S_F2: begin
            cmd.op   = wmh_pkg::OP_FMIX_P;
            state_in = S_F2_M0;
         end
         S_F2_M0: begin
            cmd.op   = wmh_pkg::OP_MUL0;
            cmd.ksel = wmh_pkg::K_FM2;
            state_in = S_F2_M1;
         end
         S_F2_M1: begin
            cmd.op   = wmh_pkg::OP_MUL1;
            cmd.ksel = wmh_pkg::K_FM2;
            state_in = S_F2_M2;
         end
         S_F2_M2: begin
            cmd.op   = wmh_pkg::OP_MUL2;
            cmd.ksel = wmh_pkg::K_FM2;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = wmh_pkg::OP_FINAL;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Wait here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = wmh_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mid_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mid_ff       <= mid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/word_mix_hash64_expand256_core.sv
// ----------------------------------------------------------------------------
// word_mix_hash64_expand256_core
// Word-wise xor, rotate and multiply hash with a 64-bit finalizer, expanded
// into a 256-bit digest of four words.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | data word, byte count, last, length
//   rsp     | out       | rsp_valid/ready    | four 64-bit digest words
//   csr     | in        | csr_wr_en          | 64-bit seed
//
// One word is accepted per pass; the shared 32x32 multiplier sets the pace,
// each 64-bit multiply being built from 32x32 partial products. After the
// accept, a pass seeds on the first word of a message, mixes a word with
// data (a word with no valid bytes is not mixed in), and finalizes on the
// last word before the output step; mid-message words skip the seeding.
// Reset is synchronous and clears the seed and message state; no clearing pass.
// A held result blocks only the final output step; the next word is taken
// while a finished digest waits.
// ----------------------------------------------------------------------------
module word_mix_hash64_expand256_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wmh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wmh_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [63:0]      csr_wr_data
);

   wmh_pkg::cmd_type  cmd;
   wmh_pkg::stat_type stat;

   wmh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

   wmh_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // An accepted word leaves the sequencer busy, so req_ready drops after each accept.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on two consecutive cycles");

   // A new result appears only at the end of a finalize sequence.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result raised while the sequencer was idle");

   // The digest words are spaced by the golden constant.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.digest_word1 == rsp_data.digest_word0 + wmh_pkg::GOLD_K)
                 && (rsp_data.digest_word3 == rsp_data.digest_word2 + wmh_pkg::GOLD_K))
      else $error("digest word expansion mismatch");

endmodule
